>>> design/tpo_pkg.sv
// Shared types and helper functions for the triangle pair overlap test.
`timescale 1ns / 1ps

package tpo_pkg;

    localparam int NUM_VERTS = 3;

    typedef struct packed {
        logic neg;
        logic zero;
    } sign_t;

    function automatic logic same_side_strict(sign_t s, sign_t t);
        return !s.zero && !t.zero && (s.neg == t.neg);
    endfunction

    function automatic logic opposite_side_strict(sign_t s, sign_t t);
        return !s.zero && !t.zero && (s.neg != t.neg);
    endfunction

endpackage

>>> design/tpo_centroid.sv
// Three-stage centroid coordinate: sum of three values divided by three, toward zero.
`timescale 1ns / 1ps

module tpo_centroid #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                          clk,
    input  logic signed [COORD_WIDTH-1:0] c0,
    input  logic signed [COORD_WIDTH-1:0] c1,
    input  logic signed [COORD_WIDTH-1:0] c2,
    output logic signed [COORD_WIDTH-1:0] mean
);

    localparam int SW    = COORD_WIDTH + 2;
    localparam int LW    = SW / 2;
    localparam int HW    = SW - LW;
    localparam int RW    = SW + 1;
    localparam int SHIFT = SW + 2;
    localparam int PW    = 2 * SW + 1;
    localparam logic [63:0] RECIP_FULL = ((64'd1 << SHIFT) + 64'd2) / 64'd3;
    localparam logic [RW-1:0] RECIP = RECIP_FULL[RW-1:0];

    logic [SW-1:0]          sum;
    logic [SW-1:0]          mag_next;
    logic                   neg1_reg;
    logic [SW-1:0]          mag_reg;
    logic [LW+RW-1:0]       plo_next;
    logic [HW+RW-1:0]       phi_next;
    logic                   neg2_reg;
    logic [LW+RW-1:0]       plo_reg;
    logic [HW+RW-1:0]       phi_reg;
    logic [PW-1:0]          prod;
    logic [COORD_WIDTH-1:0] quo;
    logic [COORD_WIDTH-1:0] mean_next;
    logic [COORD_WIDTH-1:0] mean_reg;

    always_comb
    begin
        sum = {{2{c0[COORD_WIDTH-1]}}, c0} + {{2{c1[COORD_WIDTH-1]}}, c1}
            + {{2{c2[COORD_WIDTH-1]}}, c2};
        mag_next = sum[SW-1] ? (~sum + SW'(1)) : sum;
    end

    always_comb
    begin
        plo_next = (LW+RW)'(mag_reg[LW-1:0]) * (LW+RW)'(RECIP);
        phi_next = (HW+RW)'(mag_reg[SW-1:LW]) * (HW+RW)'(RECIP);
    end

    always_comb
    begin
        prod      = (PW'(phi_reg) << LW) + PW'(plo_reg);
        quo       = prod[SHIFT +: COORD_WIDTH];
        mean_next = neg2_reg ? (~quo + COORD_WIDTH'(1)) : quo;
    end

    always_ff @(posedge clk)
    begin
        neg1_reg <= sum[SW-1];
        mag_reg  <= mag_next;
        neg2_reg <= neg1_reg;
        plo_reg  <= plo_next;
        phi_reg  <= phi_next;
        mean_reg <= mean_next;
    end

    assign mean = signed'(mean_reg);

endmodule

>>> design/tpo_side.sv
// Three-stage side-of-line sign: differences, products, then sum and sign.
`timescale 1ns / 1ps

module tpo_side
    import tpo_pkg::*;
#(
    parameter int COORD_WIDTH = 16
) (
    input  logic                          clk,
    input  logic signed [COORD_WIDTH-1:0] ax,
    input  logic signed [COORD_WIDTH-1:0] ay,
    input  logic signed [COORD_WIDTH-1:0] bx,
    input  logic signed [COORD_WIDTH-1:0] by,
    input  logic signed [COORD_WIDTH-1:0] px,
    input  logic signed [COORD_WIDTH-1:0] py,
    output sign_t                         sgn
);

    localparam int DW = COORD_WIDTH + 1;
    localparam int MW = 2 * DW;
    localparam int SW = MW + 1;

    logic signed [DW-1:0] d1_next, d2_next, d3_next, d4_next;
    logic signed [DW-1:0] d1_reg, d2_reg, d3_reg, d4_reg;
    logic signed [MW-1:0] p1_next, p2_next;
    logic signed [MW-1:0] p1_reg, p2_reg;
    logic signed [SW-1:0] total;
    sign_t                sgn_next;
    sign_t                sgn_reg;

    always_comb
    begin
        d1_next = {ax[COORD_WIDTH-1], ax} - {bx[COORD_WIDTH-1], bx};
        d2_next = {py[COORD_WIDTH-1], py} - {ay[COORD_WIDTH-1], ay};
        d3_next = {ay[COORD_WIDTH-1], ay} - {by[COORD_WIDTH-1], by};
        d4_next = {ax[COORD_WIDTH-1], ax} - {px[COORD_WIDTH-1], px};
    end

    always_comb
    begin
        p1_next = MW'(d1_reg) * MW'(d2_reg);
        p2_next = MW'(d3_reg) * MW'(d4_reg);
    end

    always_comb
    begin
        total         = {p1_reg[MW-1], p1_reg} + {p2_reg[MW-1], p2_reg};
        sgn_next.neg  = total[SW-1];
        sgn_next.zero = (total == '0);
    end

    always_ff @(posedge clk)
    begin
        d1_reg  <= d1_next;
        d2_reg  <= d2_next;
        d3_reg  <= d3_next;
        d4_reg  <= d4_next;
        p1_reg  <= p1_next;
        p2_reg  <= p2_next;
        sgn_reg <= sgn_next;
    end

    assign sgn = sgn_reg;

endmodule

>>> design/triangle_pair_overlap_test.sv
// Top level of the pipelined triangle pair overlap test.
//
// Usage:
//   Drive the twelve vertex coordinates of triangles A (first_*) and B
//   (second_*) and raise start; a transaction is taken at each rising edge
//   with start high and busy low. busy stays low, so a new pair can enter
//   every cycle and throughput is one pair per clock.
//   The decision appears on overlap together with a one-cycle done strobe.
//   The pipeline has three stages for the centroid divide by three, three
//   stages for the side-of-line difference, product and sign, and one stage
//   that combines the segment and point-in-triangle tests.
//   Results leave in acceptance order. The receiver cannot stall, so no
//   result is ever held back.
//   Reset (rst_n low, asynchronous) drops every transaction in flight and
//   clears done; the data path carries no reset.
`timescale 1ns / 1ps

module triangle_pair_overlap_test
    import tpo_pkg::*;
#(
    parameter int COORD_WIDTH = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [COORD_WIDTH-1:0] first_x0,
    input  logic signed [COORD_WIDTH-1:0] first_y0,
    input  logic signed [COORD_WIDTH-1:0] first_x1,
    input  logic signed [COORD_WIDTH-1:0] first_y1,
    input  logic signed [COORD_WIDTH-1:0] first_x2,
    input  logic signed [COORD_WIDTH-1:0] first_y2,
    input  logic signed [COORD_WIDTH-1:0] second_x0,
    input  logic signed [COORD_WIDTH-1:0] second_y0,
    input  logic signed [COORD_WIDTH-1:0] second_x1,
    input  logic signed [COORD_WIDTH-1:0] second_y1,
    input  logic signed [COORD_WIDTH-1:0] second_x2,
    input  logic signed [COORD_WIDTH-1:0] second_y2,
    output logic                          done,
    output logic                          overlap
);

    localparam int DELAY = 3;
    localparam int DEPTH = 6;

    logic signed [COORD_WIDTH-1:0] in_ax [NUM_VERTS];
    logic signed [COORD_WIDTH-1:0] in_ay [NUM_VERTS];
    logic signed [COORD_WIDTH-1:0] in_bx [NUM_VERTS];
    logic signed [COORD_WIDTH-1:0] in_by [NUM_VERTS];

    logic signed [COORD_WIDTH-1:0] ax_reg [DELAY][NUM_VERTS];
    logic signed [COORD_WIDTH-1:0] ay_reg [DELAY][NUM_VERTS];
    logic signed [COORD_WIDTH-1:0] bx_reg [DELAY][NUM_VERTS];
    logic signed [COORD_WIDTH-1:0] by_reg [DELAY][NUM_VERTS];

    logic signed [COORD_WIDTH-1:0] gax, gay, gbx, gby;

    logic [DEPTH-1:0] valid_reg;
    logic             done_reg;
    logic             overlap_reg;
    logic             overlap_next;
    logic             accept;

    sign_t sa [NUM_VERTS][NUM_VERTS];
    sign_t sb [NUM_VERTS][NUM_VERTS];
    sign_t sga [NUM_VERTS];
    sign_t sgb [NUM_VERTS];
    sign_t deg_a, deg_b;

    logic [5:0] seg_hit;
    logic       pa_hit, pb_hit;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    assign in_ax[0] = first_x0;
    assign in_ax[1] = first_x1;
    assign in_ax[2] = first_x2;
    assign in_ay[0] = first_y0;
    assign in_ay[1] = first_y1;
    assign in_ay[2] = first_y2;
    assign in_bx[0] = second_x0;
    assign in_bx[1] = second_x1;
    assign in_bx[2] = second_x2;
    assign in_by[0] = second_y0;
    assign in_by[1] = second_y1;
    assign in_by[2] = second_y2;

    always_ff @(posedge clk)
    begin
        for (int v = 0; v < NUM_VERTS; v++)
        begin
            ax_reg[0][v] <= in_ax[v];
            ay_reg[0][v] <= in_ay[v];
            bx_reg[0][v] <= in_bx[v];
            by_reg[0][v] <= in_by[v];
            for (int s = 1; s < DELAY; s++)
            begin
                ax_reg[s][v] <= ax_reg[s-1][v];
                ay_reg[s][v] <= ay_reg[s-1][v];
                bx_reg[s][v] <= bx_reg[s-1][v];
                by_reg[s][v] <= by_reg[s-1][v];
            end
        end
    end

    tpo_centroid #(.COORD_WIDTH(COORD_WIDTH)) u_gax (
        .clk(clk), .c0(first_x0), .c1(first_x1), .c2(first_x2), .mean(gax)
    );
    tpo_centroid #(.COORD_WIDTH(COORD_WIDTH)) u_gay (
        .clk(clk), .c0(first_y0), .c1(first_y1), .c2(first_y2), .mean(gay)
    );
    tpo_centroid #(.COORD_WIDTH(COORD_WIDTH)) u_gbx (
        .clk(clk), .c0(second_x0), .c1(second_x1), .c2(second_x2), .mean(gbx)
    );
    tpo_centroid #(.COORD_WIDTH(COORD_WIDTH)) u_gby (
        .clk(clk), .c0(second_y0), .c1(second_y1), .c2(second_y2), .mean(gby)
    );

    for (genvar i = 0; i < NUM_VERTS; i++)
    begin : g_line
        localparam int K = (i + 1) % NUM_VERTS;
        for (genvar j = 0; j < NUM_VERTS; j++)
        begin : g_pt
            tpo_side #(.COORD_WIDTH(COORD_WIDTH)) u_sa (
                .clk(clk),
                .ax(ax_reg[DELAY-1][i]), .ay(ay_reg[DELAY-1][i]),
                .bx(ax_reg[DELAY-1][K]), .by(ay_reg[DELAY-1][K]),
                .px(bx_reg[DELAY-1][j]), .py(by_reg[DELAY-1][j]),
                .sgn(sa[i][j])
            );
            tpo_side #(.COORD_WIDTH(COORD_WIDTH)) u_sb (
                .clk(clk),
                .ax(bx_reg[DELAY-1][i]), .ay(by_reg[DELAY-1][i]),
                .bx(bx_reg[DELAY-1][K]), .by(by_reg[DELAY-1][K]),
                .px(ax_reg[DELAY-1][j]), .py(ay_reg[DELAY-1][j]),
                .sgn(sb[i][j])
            );
        end
        tpo_side #(.COORD_WIDTH(COORD_WIDTH)) u_sga (
            .clk(clk),
            .ax(ax_reg[DELAY-1][i]), .ay(ay_reg[DELAY-1][i]),
            .bx(ax_reg[DELAY-1][K]), .by(ay_reg[DELAY-1][K]),
            .px(gax), .py(gay),
            .sgn(sga[i])
        );
        tpo_side #(.COORD_WIDTH(COORD_WIDTH)) u_sgb (
            .clk(clk),
            .ax(bx_reg[DELAY-1][i]), .ay(by_reg[DELAY-1][i]),
            .bx(bx_reg[DELAY-1][K]), .by(by_reg[DELAY-1][K]),
            .px(gbx), .py(gby),
            .sgn(sgb[i])
        );
    end

    tpo_side #(.COORD_WIDTH(COORD_WIDTH)) u_deg_a (
        .clk(clk),
        .ax(ax_reg[DELAY-1][0]), .ay(ay_reg[DELAY-1][0]),
        .bx(ax_reg[DELAY-1][1]), .by(ay_reg[DELAY-1][1]),
        .px(ax_reg[DELAY-1][2]), .py(ay_reg[DELAY-1][2]),
        .sgn(deg_a)
    );
    tpo_side #(.COORD_WIDTH(COORD_WIDTH)) u_deg_b (
        .clk(clk),
        .ax(bx_reg[DELAY-1][0]), .ay(by_reg[DELAY-1][0]),
        .bx(bx_reg[DELAY-1][1]), .by(by_reg[DELAY-1][1]),
        .px(bx_reg[DELAY-1][2]), .py(by_reg[DELAY-1][2]),
        .sgn(deg_b)
    );

    always_comb
    begin
        seg_hit[0] = !(same_side_strict(sa[0][1], sa[0][2])
                    || same_side_strict(sb[1][0], sb[1][1]));
        seg_hit[1] = !(same_side_strict(sa[0][2], sa[0][0])
                    || same_side_strict(sb[2][0], sb[2][1]));
        seg_hit[2] = !(same_side_strict(sa[1][0], sa[1][1])
                    || same_side_strict(sb[0][1], sb[0][2]));
        seg_hit[3] = !(same_side_strict(sa[1][2], sa[1][0])
                    || same_side_strict(sb[2][1], sb[2][2]));
        seg_hit[4] = !(same_side_strict(sa[2][0], sa[2][1])
                    || same_side_strict(sb[0][2], sb[0][0]));
        seg_hit[5] = !(same_side_strict(sa[2][1], sa[2][2])
                    || same_side_strict(sb[1][2], sb[1][0]));
        pa_hit = !deg_b.zero;
        pb_hit = !deg_a.zero;
        for (int i = 0; i < NUM_VERTS; i++)
        begin
            if (opposite_side_strict(sb[i][0], sgb[i]))
            begin
                pa_hit = 1'b0;
            end
            if (opposite_side_strict(sa[i][0], sga[i]))
            begin
                pb_hit = 1'b0;
            end
        end
        overlap_next = (|seg_hit) || pa_hit || pb_hit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= {valid_reg[DEPTH-2:0], accept};
            done_reg  <= valid_reg[DEPTH-1];
        end
    end

    always_ff @(posedge clk)
    begin
        overlap_reg <= overlap_next;
    end

    assign done    = done_reg;
    assign overlap = overlap_reg;

    a_done_follows_accept: assert property (
        @(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, DEPTH + 1)
    ) else $error("done strobe without a matching accepted transaction");

    a_accept_yields_done: assert property (
        @(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##7 done
    ) else $error("accepted transaction produced no result");

    a_never_busy: assert property (
        @(posedge clk) disable iff (!rst_n)
        (valid_reg != '0) |-> !busy
    ) else $error("busy raised while transactions are in flight");

endmodule
